// ----- rtl/spq_pkg.sv -----
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_NULL  = 3'd1;
	localparam logic [2:0] ST_DUP   = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef struct packed {
		logic [15:0]        handle;
		logic [7:0]         etype;
		logic signed [31:0] prio;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} spq_ctrl_t;

endpackage

// ----- rtl/stable_priority_queue.sv -----
// stable priority queue, DEPTH sorted cells in a shift chain
// done is registered from the update state, which follows the compare state
// operations do not overlap: busy holds off a new one (accept, compare in all cells, update)
// busy stays high from the accept edge until the result cycle
// reset clears the fill count and the sequencer; the cell payload is not reset
// the receiver cannot stall: done is high for exactly one cycle per operation
module stable_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [15:0]        item_handle,
	input  logic [7:0]         event_type,
	input  logic signed [31:0] priority_req,
	output logic               done,
	output logic [2:0]         status,
	output logic [15:0]        out_handle,
	output logic [7:0]         out_type,
	output logic signed [31:0] out_priority,
	output logic [4:0]         entry_count
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]                 state_q;
	logic                       action_q;
	spq_pkg::entry_t            req_q;
	logic [spq_pkg::CNT_W-1:0]  count_q;

	logic                       done_q;
	logic [2:0]                 status_q;
	spq_pkg::entry_t            out_q;

	spq_pkg::spq_ctrl_t         ctrl;
	spq_pkg::entry_t            cell_entry [spq_pkg::DEPTH];
	logic [spq_pkg::DEPTH-1:0]  keep_vec;
	logic [spq_pkg::DEPTH-1:0]  hit_vec;
	logic [spq_pkg::DEPTH-1:0]  occ_vec;

	logic                       accept;
	logic                       dup;
	logic                       is_empty;
	logic                       is_full;
	logic [2:0]                 upd_status;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign dup      = |hit_vec;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));

	// occupancy is a thermometer of the fill count
	always_comb begin
		for (int i = 0; i < spq_pkg::DEPTH; i++) begin
			occ_vec[i] = (spq_pkg::CNT_W'(i) < count_q);
		end
	end

	// status of the operation in the update cycle, in rejection order
	always_comb begin
		if (action_q == spq_pkg::ACT_REMOVE) begin
			upd_status = is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
		end else if (req_q.handle == '0) begin
			upd_status = spq_pkg::ST_NULL;
		end else if (dup) begin
			upd_status = spq_pkg::ST_DUP;
		end else if (is_full) begin
			upd_status = spq_pkg::ST_FULL;
		end else begin
			upd_status = spq_pkg::ST_OK;
		end
	end

	// cell commands: compare everywhere, then shift in or shift out
	always_comb begin
		ctrl.cmp = (state_q == S_CMP);
		ctrl.ins = (state_q == S_UPD) && (action_q == spq_pkg::ACT_INSERT)
			&& (upd_status == spq_pkg::ST_OK);
		ctrl.rem = (state_q == S_UPD) && (action_q == spq_pkg::ACT_REMOVE)
			&& (upd_status == spq_pkg::ST_OK);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_CMP;
				end
				S_CMP: state_q <= S_UPD;
				S_UPD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture on the start transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= action;
			req_q.handle <= item_handle;
			req_q.etype  <= event_type;
			req_q.prio   <= priority_req;
		end
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_UPD);
			if (ctrl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// result payload; the head cell is the entry that leaves on a remove
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			status_q <= upd_status;
			if (ctrl.rem) begin
				out_q <= cell_entry[0];
			end else begin
				out_q <= '0;
			end
		end
	end

	// the cell chain
	for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_k;

		if (g == 0) begin : g_head
			assign left_e = req_q;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[g-1];
			assign left_k = keep_vec[g-1];
		end

		if (g == spq_pkg::DEPTH - 1) begin : g_tail
			assign right_e = cell_entry[g];
		end else begin : g_body
			assign right_e = cell_entry[g+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_entry   (req_q),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_keep   (left_k),
			.occ         (occ_vec[g]),
			.entry       (cell_entry[g]),
			.keep        (keep_vec[g]),
			.hit         (hit_vec[g])
		);
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_handle   = out_q.handle;
	assign out_type     = out_q.etype;
	assign out_priority = out_q.prio;
	assign entry_count  = 5'(count_q);

endmodule

// ----- rtl/spq_cell.sv -----
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::spq_ctrl_t ctrl,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	input  logic               left_keep,
	input  logic               occ,
	output spq_pkg::entry_t    entry,
	output logic               keep,
	output logic               hit
);

	spq_pkg::entry_t entry_q;
	logic            keep_q;
	logic            hit_q;

	// compare flags, sampled in the cycle before the update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (ctrl.cmp) begin
			keep_q <= occ && (entry_q.prio <= new_entry.prio);
			hit_q  <= occ && (entry_q.handle == new_entry.handle);
		end
	end

	// keep, take the new entry, or shift from a neighbor
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!keep_q) begin
				if (left_keep) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign keep  = keep_q;
	assign hit   = hit_q;

endmodule

// ----- rtl/spq_checker.sv -----
module spq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [15:0] out_handle,
	input logic [4:0]  entry_count
);

	// every accepted operation yields its result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("no result after accepted operation");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted operation");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_EMPTY) |-> (entry_count == '0 && out_handle == '0))
		else $error("empty status with entries or a handle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_FULL) |-> (entry_count == 5'(spq_pkg::DEPTH)))
		else $error("full status with a free cell");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= 5'(spq_pkg::DEPTH)))
		else $error("entry count above depth");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.out_handle  (out_handle),
	.entry_count (entry_count)
);

// ----- bench/tb_stable_priority_queue.sv -----
module tb_stable_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	// run length and watchdog
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 8;
	localparam int MAX_PRINTS   = 40;

	// one result as seen on the result ports
	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        handle;
		logic [7:0]         etype;
		logic signed [31:0] prio;
		logic [4:0]         count;
	} op_result_t;

	// directed stimulus row; handle and type step by one per repetition
	typedef struct {
		logic               act;
		logic [15:0]        handle;
		logic [7:0]         etype;
		logic signed [31:0] prio;
		int                 reps;
		bit                 typed;
		op_result_t         res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [15:0]        item_handle;
	logic [7:0]         event_type;
	logic signed [31:0] priority_req;
	logic               done;
	logic [2:0]         status;
	logic [15:0]        out_handle;
	logic [7:0]         out_type;
	logic signed [31:0] out_priority;
	logic [4:0]         entry_count;

	// mirror of the queue contents, sorted by priority then arrival
	spq_pkg::entry_t queue_model[$];
	// results still owed by the block, oldest first
	op_result_t owed_results[$];
	stim_row_t  stim_rows[$];

	// typed expectation riding along with the current command, if any
	bit         row_typed;
	op_result_t row_result;

	int  mismatches;
	int  cycles;

	stable_priority_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.item_handle  (item_handle),
		.event_type   (event_type),
		.priority_req (priority_req),
		.done         (done),
		.status       (status),
		.out_handle   (out_handle),
		.out_type     (out_type),
		.out_priority (out_priority),
		.entry_count  (entry_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_stable_priority_queue: FAIL");
			$finish;
		end
	end

	// apply one operation to the mirror and return the result it should produce
	function automatic op_result_t apply_op(logic act, logic [15:0] h, logic [7:0] t,
			logic signed [31:0] p);
		op_result_t      r;
		spq_pkg::entry_t e;
		int              pos;
		bit              dup;
		r = '0;
		dup = 1'b0;
		if (act == spq_pkg::ACT_INSERT) begin
			foreach (queue_model[i])
				if (queue_model[i].handle == h)
					dup = 1'b1;
			// null beats duplicate beats full
			if (h == 16'd0) begin
				r.status = spq_pkg::ST_NULL;
			end else if (dup) begin
				r.status = spq_pkg::ST_DUP;
			end else if (queue_model.size() >= spq_pkg::DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				// go behind every entry of equal or smaller priority
				pos = 0;
				while (pos < queue_model.size() && queue_model[pos].prio <= p)
					pos++;
				e.handle = h;
				e.etype  = t;
				e.prio   = p;
				queue_model.insert(pos, e);
				r.status = spq_pkg::ST_OK;
			end
		end else if (queue_model.size() == 0) begin
			r.status = spq_pkg::ST_EMPTY;
		end else begin
			e = queue_model.pop_front();
			r.status = spq_pkg::ST_OK;
			r.handle = e.handle;
			r.etype  = e.etype;
			r.prio   = e.prio;
		end
		r.count = 5'(queue_model.size());
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s expected %h got %h", cycles, field, want, got);
		mismatches++;
	endtask

	// result checker and command tracker, both on the rising edge
	always @(posedge clk) begin
		op_result_t got;
		op_result_t want;
		op_result_t model_res;
		if (arst_n) begin
			if (done) begin
				got = {status, out_handle, out_type, out_priority, entry_count};
				if (owed_results.size() == 0) begin
					report_mismatch("unexpected result, status", 32'd0, 32'(got.status));
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(got.status));
					if (got.handle !== want.handle)
						report_mismatch("out_handle", 32'(want.handle), 32'(got.handle));
					if (got.etype !== want.etype)
						report_mismatch("out_type", 32'(want.etype), 32'(got.etype));
					if (got.prio !== want.prio)
						report_mismatch("out_priority", want.prio, got.prio);
					if (got.count !== want.count)
						report_mismatch("entry_count", 32'(want.count), 32'(got.count));
				end
			end
			// command transfer: mirror always advances, typed rows override the result
			if (start && !busy) begin
				model_res = apply_op(action, item_handle, event_type, priority_req);
				owed_results.push_back(row_typed ? row_result : model_res);
			end
		end
	end

	// drive one command from a falling edge, hold it until the transfer,
	// and return on the following falling edge with start still high
	task automatic issue(logic act, logic [15:0] h, logic [7:0] t, logic signed [31:0] p,
			bit typed, op_result_t res);
		action       = act;
		item_handle  = h;
		event_type   = t;
		priority_req = p;
		row_typed    = typed;
		row_result   = res;
		start        = 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic idle(int n);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// sender holds off until every owed result has come back
	task automatic wait_drained();
		start = 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
	endtask

	// mostly back to back or short gaps, now and then a long one
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		else if (sel < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic void add_row(logic act, logic [15:0] h, logic [7:0] t,
			logic signed [31:0] p, int reps, bit typed, logic [2:0] st,
			logic [15:0] oh, logic [7:0] ot, logic signed [31:0] op, logic [4:0] cnt);
		stim_row_t r;
		r.act    = act;
		r.handle = h;
		r.etype  = t;
		r.prio   = p;
		r.reps   = reps;
		r.typed  = typed;
		r.res    = {st, oh, ot, op, cnt};
		stim_rows.push_back(r);
	endfunction

	initial begin
		logic               act;
		logic [15:0]        h;
		logic [7:0]         t;
		logic signed [31:0] p;
		int                 sel;
		int                 ins_pct;

		arst_n       = 1'b0;
		start        = 1'b0;
		action       = spq_pkg::ACT_INSERT;
		item_handle  = 16'd0;
		event_type   = 8'd0;
		priority_req = 32'sd0;
		row_typed    = 1'b0;
		row_result   = '0;
		mismatches   = 0;
		cycles       = 0;

		// remove on an empty queue right after reset
		add_row(spq_pkg::ACT_REMOVE, 16'h0000, 8'h00, 32'sd0, 1, 1,
			spq_pkg::ST_EMPTY, 16'h0000, 8'h00, 32'sd0, 5'd0);
		// null handle is rejected
		add_row(spq_pkg::ACT_INSERT, 16'h0000, 8'h5A, 32'sd123, 1, 1,
			spq_pkg::ST_NULL, 16'h0000, 8'h00, 32'sd0, 5'd0);
		// field extremes
		add_row(spq_pkg::ACT_INSERT, 16'h0001, 8'hFF, 32'sh7FFFFFFF, 1, 1,
			spq_pkg::ST_OK, 16'h0000, 8'h00, 32'sd0, 5'd1);
		add_row(spq_pkg::ACT_INSERT, 16'hFFFF, 8'h00, 32'sh80000000, 1, 1,
			spq_pkg::ST_OK, 16'h0000, 8'h00, 32'sd0, 5'd2);
		// duplicate handle, then null with every other field at max
		add_row(spq_pkg::ACT_INSERT, 16'h0001, 8'h00, 32'sd0, 1, 1,
			spq_pkg::ST_DUP, 16'h0000, 8'h00, 32'sd0, 5'd2);
		add_row(spq_pkg::ACT_INSERT, 16'h0000, 8'hFF, 32'sh7FFFFFFF, 1, 1,
			spq_pkg::ST_NULL, 16'h0000, 8'h00, 32'sd0, 5'd2);
		// two equal priorities: must leave in arrival order
		add_row(spq_pkg::ACT_INSERT, 16'h5555, 8'h55, 32'sd0, 1, 1,
			spq_pkg::ST_OK, 16'h0000, 8'h00, 32'sd0, 5'd3);
		add_row(spq_pkg::ACT_INSERT, 16'hAAAA, 8'hAA, 32'sd0, 1, 1,
			spq_pkg::ST_OK, 16'h0000, 8'h00, 32'sd0, 5'd4);
		// removes carry junk in the ignored fields
		add_row(spq_pkg::ACT_REMOVE, 16'h1234, 8'h77, -32'sd5, 1, 1,
			spq_pkg::ST_OK, 16'hFFFF, 8'h00, 32'sh80000000, 5'd3);
		add_row(spq_pkg::ACT_REMOVE, 16'h0000, 8'hFF, 32'sh7FFFFFFF, 1, 1,
			spq_pkg::ST_OK, 16'h5555, 8'h55, 32'sd0, 5'd2);
		add_row(spq_pkg::ACT_REMOVE, 16'hFFFF, 8'h00, 32'sh80000000, 1, 1,
			spq_pkg::ST_OK, 16'hAAAA, 8'hAA, 32'sd0, 5'd1);
		// fill to capacity with a run of equal priorities
		add_row(spq_pkg::ACT_INSERT, 16'h0100, 8'h10, -32'sd1, spq_pkg::DEPTH - 1, 0,
			spq_pkg::ST_OK, 16'h0000, 8'h00, 32'sd0, 5'd0);
		// on a full queue: full, then duplicate and null take precedence
		add_row(spq_pkg::ACT_INSERT, 16'h7777, 8'h77, 32'sd7, 1, 1,
			spq_pkg::ST_FULL, 16'h0000, 8'h00, 32'sd0, 5'(spq_pkg::DEPTH));
		add_row(spq_pkg::ACT_INSERT, 16'h0001, 8'h01, 32'sd7, 1, 1,
			spq_pkg::ST_DUP, 16'h0000, 8'h00, 32'sd0, 5'(spq_pkg::DEPTH));
		add_row(spq_pkg::ACT_INSERT, 16'h0000, 8'h01, 32'sd7, 1, 1,
			spq_pkg::ST_NULL, 16'h0000, 8'h00, 32'sd0, 5'(spq_pkg::DEPTH));
		// drain: the equal-priority run first, in order, then the max entry
		add_row(spq_pkg::ACT_REMOVE, 16'h0000, 8'h00, 32'sd0, spq_pkg::DEPTH - 1, 0,
			spq_pkg::ST_OK, 16'h0000, 8'h00, 32'sd0, 5'd0);
		add_row(spq_pkg::ACT_REMOVE, 16'h0000, 8'h00, 32'sd0, 1, 1,
			spq_pkg::ST_OK, 16'h0001, 8'hFF, 32'sh7FFFFFFF, 5'd0);
		add_row(spq_pkg::ACT_REMOVE, 16'h0000, 8'h00, 32'sd0, 1, 1,
			spq_pkg::ST_EMPTY, 16'h0000, 8'h00, 32'sd0, 5'd0);

		// reset asserted from the start, released on a falling edge
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[k]) begin
			for (int j = 0; j < stim_rows[k].reps; j++) begin
				issue(stim_rows[k].act, stim_rows[k].handle + 16'(j),
					stim_rows[k].etype + 8'(j), stim_rows[k].prio,
					stim_rows[k].typed, stim_rows[k].res);
				idle(gap_len());
			end
		end
		wait_drained();

		// random part: alternating insert-heavy and remove-heavy stretches so
		// the queue swings between full and empty; a small handle pool keeps
		// duplicates common and a narrow priority band keeps ties common
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			ins_pct = ((n / 120) % 2 == 0) ? 70 : 30;
			act = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::ACT_INSERT
				: spq_pkg::ACT_REMOVE;
			sel = $urandom_range(0, 99);
			if (sel < 5)
				h = 16'd0;
			else if (sel < 85)
				h = 16'($urandom_range(1, 40));
			else
				h = 16'($urandom);
			sel = $urandom_range(0, 99);
			if (sel < 60)
				p = $signed($urandom_range(0, 8)) - 4;
			else if (sel < 65)
				p = 32'sh7FFFFFFF;
			else if (sel < 70)
				p = 32'sh80000000;
			else
				p = $signed($urandom);
			t = 8'($urandom);
			issue(act, h, t, p, 1'b0, '0);
			// periodic full drain, one stretch with no random gaps
			if (n % 250 == 249)
				wait_drained();
			else if (n < 400 || n >= 520)
				idle(gap_len());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0) begin
			$display("tb_stable_priority_queue: PASS");
		end else begin
			$display("tb_stable_priority_queue: FAIL");
		end
		$finish;
	end

endmodule
